// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASRT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASRT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/segy_pkg.sv
// Package with types and constants of the sample converter.
package segy_pkg;
    localparam logic [2:0] FMT_IBM  = 3'd1;
    localparam logic [2:0] FMT_INT4 = 3'd2;
    localparam logic [2:0] FMT_INT2 = 3'd3;
    localparam logic [2:0] FMT_IEEE = 3'd5;
    localparam logic [31:0] MAX_FINITE = 32'h7F7F_FFFF;

    // Kind of conversion carried down the pipeline.
    typedef enum logic [1:0] {
        K_IBM  = 2'd0,
        K_INT  = 2'd1,
        K_PASS = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    // Stage-1 to stage-2 payload: kind, sign, magnitude, IBM exponent field and last flag.
    typedef struct packed {
        t_kind       kind;
        logic        sign;
        logic [31:0] mag;
        logic [6:0]  ibm_exp;
        logic        last;
    } t_s1;
endpackage

// File: hw/rtl/segy_norm.sv
// Leading-zero count and normalizing shift stage of the converter.
module segy_norm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_mag,
    output logic        o_vld,
    output logic [31:0] o_norm,
    output logic [4:0]  o_lz,
    output logic        o_zero
);
    logic [4:0]  n_lz;
    logic [31:0] r_norm;
    logic [4:0]  r_lz;
    logic        r_zero;
    logic        r_vld;

    always_comb begin
        n_lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_mag[i]) n_lz = 5'(31 - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_norm <= i_mag << n_lz;
            r_lz   <= n_lz;
            r_zero <= (i_mag == 32'd0);
        end
    end

    assign o_vld  = r_vld;
    assign o_norm = r_norm;
    assign o_lz   = r_lz;
    assign o_zero = r_zero;

    `include "assert_macros.svh"
    `ASRT_IMP(a_norm_msb, i_clk, i_rst_n, r_vld && !r_zero, r_norm[31])
    `ASRT_IMP(a_zero_norm, i_clk, i_rst_n, r_vld && r_zero, r_norm == 32'd0)
    `ASRT_IMP(a_zero_lz, i_clk, i_rst_n, r_vld && r_zero, r_lz == 5'd0)
endmodule

// File: hw/rtl/segy_sample_to_ieee_float_top.sv
// Top level of the seismic sample to IEEE-754 single converter.
// Usage: sample words enter on the s_axis channel (tdata = raw_sample,
// tlast = last_of_trace) and converted words leave on m_axis (tdata =
// ieee_bits, tlast = last_out, tuser = format_error). The sample code is
// written through i_cfg_we/i_cfg_wdata while the block is idle; it is
// sampled as each request enters.
// The pipeline has three register stages: format decode and sign split,
// leading-zero normalize, and exponent, rounding and special cases feeding
// the output register.
// A request accepted on s_axis passes the stage-1, normalize and output
// registers in that order before it shows on m_axis_tvalid. One request can
// enter every cycle while the output register is free or being taken.
// When the receiver stalls, the whole pipeline holds, and s_axis_tready
// drops only if the output register is full and not taken, so nothing is
// lost or repeated. Reset clears all valid bits and sets the code to IBM
// hexadecimal float.
module segy_sample_to_ieee_float_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // raw_sample [31:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // ieee_bits [31:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // format_error [0]
);
    logic [2:0] r_fmt;
    logic       w_en;

    // The pipeline advances whenever the output slot is free or being taken.
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= segy_pkg::FMT_IBM;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // Stage 1: decode the format and form sign and magnitude.
    segy_pkg::t_s1 n_s1, r_s1;
    logic          r_v1;
    logic [31:0]   w_x;
    logic [31:0]   w_h;

    always_comb begin
        w_x = s_axis_tdata;
        w_h = {{16{w_x[15]}}, w_x[15:0]};
        n_s1.last    = s_axis_tlast;
        n_s1.ibm_exp = w_x[30:24];
        n_s1.sign    = 1'b0;
        n_s1.mag     = 32'd0;
        n_s1.kind    = segy_pkg::K_ERR;
        case (r_fmt)
            segy_pkg::FMT_IBM: begin
                n_s1.kind = segy_pkg::K_IBM;
                n_s1.sign = w_x[31];
                n_s1.mag  = {8'd0, w_x[23:0]};
            end
            segy_pkg::FMT_INT4: begin
                n_s1.kind = segy_pkg::K_INT;
                n_s1.sign = w_x[31];
                n_s1.mag  = w_x[31] ? (~w_x + 32'd1) : w_x;
            end
            segy_pkg::FMT_INT2: begin
                n_s1.kind = segy_pkg::K_INT;
                n_s1.sign = w_h[31];
                n_s1.mag  = w_h[31] ? (~w_h + 32'd1) : w_h;
            end
            segy_pkg::FMT_IEEE: begin
                n_s1.kind = segy_pkg::K_PASS;
                n_s1.mag  = w_x;
            end
            default: begin
                n_s1.kind = segy_pkg::K_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
        end
        if (w_en) r_s1 <= n_s1;
    end

    // Stage 2: normalize; side fields ride alongside.
    logic          w_v2;
    logic [31:0]   w_norm;
    logic [4:0]    w_lz;
    logic          w_zero;
    segy_pkg::t_s1 r_s2;

    segy_norm u_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_v1),
        .i_mag  (r_s1.mag),
        .o_vld  (w_v2),
        .o_norm (w_norm),
        .o_lz   (w_lz),
        .o_zero (w_zero)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) r_s2 <= r_s1;
    end

    // Stage 3: exponent, rounding and special cases.
    logic [31:0] n_bits;
    logic        n_err;
    logic [9:0]  w_e;       // signed biased exponent for IBM
    logic [23:0] w_m;       // rounded mantissa with hidden bit
    logic        w_rnd;
    logic [24:0] w_ms;
    logic [7:0]  w_ie;

    always_comb begin
        // IBM: fraction MSB sits at bit 23 of mag, i.e. lz >= 8.
        w_e = 10'({3'd0, r_s2.ibm_exp}) * 10'd4 - 10'd256 - 10'd1 + 10'd127 + 10'd8
              - 10'({5'd0, w_lz});
        w_rnd = w_norm[7] && (w_norm[6:0] != 7'd0 || w_norm[8]);
        w_ms  = {1'b0, w_norm[31:8]} + 25'(w_rnd);
        w_ie  = 8'd158 - 8'({3'd0, w_lz}) + 8'(w_ms[24]);
        w_m   = w_ms[24] ? w_ms[24:1] : w_ms[23:0];
        n_err  = 1'b0;
        n_bits = 32'd0;
        case (r_s2.kind)
            segy_pkg::K_IBM: begin
                if (w_zero) n_bits = 32'd0;
                else if (!w_e[9] && w_e >= 10'd255)
                    n_bits = {r_s2.sign, segy_pkg::MAX_FINITE[30:0]};
                else if (w_e[9] || w_e == 10'd0) n_bits = {r_s2.sign, 31'd0};
                else n_bits = {r_s2.sign, w_e[7:0], w_norm[30:8]};
            end
            segy_pkg::K_INT: begin
                if (w_zero) n_bits = 32'd0;
                else n_bits = {r_s2.sign, w_ie, w_m[22:0]};
            end
            segy_pkg::K_PASS: n_bits = r_s2.mag;
            default: n_err = 1'b1;
        endcase
    end

    logic [31:0] r_bits;
    logic        r_err, r_last, r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= w_v2;
        end
        if (w_en) begin
            r_bits <= n_bits;
            r_err  <= n_err;
            r_last <= r_s2.last;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_bits;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_err;

    `include "assert_macros.svh"
    `ASRT_IMP(a_err_zero, i_clk, i_rst_n, r_v4 && r_err, r_bits == 32'd0)
    `ASRT_NXT(a_hold, i_clk, i_rst_n, r_v4 && !m_axis_tready,
              r_v4 && $stable(r_bits) && $stable(r_last))
    `ASRT_NXT(a_advance, i_clk, i_rst_n, w_en && w_v2, r_v4)
endmodule
